// ===== src/dvoc_pkg.sv =====
// dvoc_pkg: shared widths, opcode codes and defaults for the distinct value counter
// used by the counter unit, its checker and its bench
package dvoc_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int VALUE_W      = 32;
    localparam int COUNT_W      = 32;
    localparam int ENTRY_W      = VALUE_W + COUNT_W;

    // stream layout
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 64;
    localparam int OUT_USER_W = 2;

    // request kinds carried on s_axis_tuser
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_FLUSH  = 1'b1;

    // bit positions in m_axis_tuser
    localparam int UB_ENTRY_VALID   = 0;
    localparam int UB_OVERFLOW_SEEN = 1;

    typedef logic [VALUE_W-1:0] t_value;
    typedef logic [COUNT_W-1:0] t_count;

endpackage

// ===== src/distinct_value_occurrence_counter_unit.sv =====
// distinct_value_occurrence_counter_unit: table of distinct values and their counts
// depends on dvoc_pkg and dvoc_ram
//
//  channel | dir | tdata                                   | tuser                        | tlast
//  s_axis  | in  | [31:0] sample_value (signed)            | [0] opcode                   | -
//  m_axis  | out | [31:0] entry_value, [63:32] entry_count | [0] entry_valid, [1] ovf_seen | last_entry
//
// an insert walks the stored entries from address zero until a match or the fill count,
// one address a cycle through the single read port of the entry ram
// a flush emits the stored entries in address order (one empty result for an empty table), and
// waits whenever the output register is held by m_axis_tready low; reset clears the state,
// fill count, overflow flag and output valid but no entries; entries beyond the count go unused
// inserts are accepted while the last flush result still waits in the output register
module distinct_value_occurrence_counter_unit #(
    parameter int CAPACITY = dvoc_pkg::CAPACITY_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [dvoc_pkg::IN_DATA_W-1:0]   s_axis_tdata,  // [31:0] sample_value
    input  logic                             s_axis_tuser,  // [0] opcode
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [dvoc_pkg::OUT_DATA_W-1:0]  m_axis_tdata,  // [31:0] entry_value, [63:32] entry_count
    output logic [dvoc_pkg::OUT_USER_W-1:0]  m_axis_tuser,  // [0] entry_valid, [1] overflow_seen
    output logic                             m_axis_tlast   // last_entry
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int UW = $clog2(CAPACITY + 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SRCH  = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;

    logic [1:0]                        r_state, n_state;
    logic [AW-1:0]                     r_idx, n_idx;
    logic [UW-1:0]                     r_used, n_used;
    logic                              r_ovf, n_ovf;
    dvoc_pkg::t_value                  r_sample, n_sample;
    logic                              r_out_valid, n_out_valid;
    logic [dvoc_pkg::OUT_DATA_W-1:0]   r_out_data, n_out_data;
    logic [dvoc_pkg::OUT_USER_W-1:0]   r_out_user, n_out_user;
    logic                              r_out_last, n_out_last;

    logic                              ram_we;
    logic [AW-1:0]                     ram_waddr;
    logic [dvoc_pkg::ENTRY_W-1:0]      ram_wdata;
    logic                              ram_re;
    logic [AW-1:0]                     ram_raddr;
    logic [dvoc_pkg::ENTRY_W-1:0]      ram_rdata;

    dvoc_pkg::t_value                  rd_value;
    dvoc_pkg::t_count                  rd_count;
    dvoc_pkg::t_count                  cnt_inc;
    logic [UW-1:0]                     idx_nx;
    logic                              more;
    logic                              hit;
    logic                              in_acc;
    logic                              out_free;

    dvoc_ram #(
        .WIDTH (dvoc_pkg::ENTRY_W),
        .DEPTH (CAPACITY),
        .ADDR_W(AW)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign rd_value = ram_rdata[dvoc_pkg::VALUE_W-1:0];
    assign rd_count = ram_rdata[dvoc_pkg::ENTRY_W-1:dvoc_pkg::VALUE_W];
    assign cnt_inc  = (rd_count == '1) ? rd_count : rd_count + dvoc_pkg::COUNT_W'(1);
    assign hit      = (rd_value == r_sample);
    assign idx_nx   = UW'(r_idx) + UW'(1);
    assign more     = (idx_nx < r_used);
    assign out_free = !r_out_valid || m_axis_tready;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_used      = r_used;
        n_ovf       = r_ovf;
        n_sample    = r_sample;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_data  = r_out_data;
        n_out_user  = r_out_user;
        n_out_last  = r_out_last;
        ram_we      = 1'b0;
        ram_waddr   = r_idx;
        ram_wdata   = {cnt_inc, rd_value};
        ram_re      = 1'b0;
        ram_raddr   = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_idx = '0;
                    if (s_axis_tuser == dvoc_pkg::OP_FLUSH) begin
                        ram_re  = 1'b1;
                        n_state = ST_FLUSH;
                    end else begin
                        n_sample = s_axis_tdata;
                        if (r_used == '0) begin
                            // empty table: first value goes straight to entry zero
                            ram_we    = 1'b1;
                            ram_waddr = '0;
                            ram_wdata = {dvoc_pkg::COUNT_W'(1), s_axis_tdata};
                            n_used    = UW'(1);
                        end else begin
                            ram_re  = 1'b1;
                            n_state = ST_SRCH;
                        end
                    end
                end
            end
            ST_SRCH: begin
                if (hit) begin
                    ram_we  = 1'b1;
                    n_state = ST_IDLE;
                end else if (more) begin
                    ram_re    = 1'b1;
                    ram_raddr = idx_nx[AW-1:0];
                    n_idx     = idx_nx[AW-1:0];
                end else begin
                    n_state = ST_IDLE;
                    if (r_used < UW'(CAPACITY)) begin
                        ram_we    = 1'b1;
                        ram_waddr = r_used[AW-1:0];
                        ram_wdata = {dvoc_pkg::COUNT_W'(1), r_sample};
                        n_used    = r_used + UW'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                end
            end
            ST_FLUSH: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_user[dvoc_pkg::UB_OVERFLOW_SEEN] = r_ovf;
                    if (r_used == '0) begin
                        n_out_data = '0;
                        n_out_user[dvoc_pkg::UB_ENTRY_VALID] = 1'b0;
                        n_out_last = 1'b1;
                    end else begin
                        n_out_data = ram_rdata;
                        n_out_user[dvoc_pkg::UB_ENTRY_VALID] = 1'b1;
                        n_out_last = !more;
                    end
                    if ((r_used != '0) && more) begin
                        ram_re    = 1'b1;
                        ram_raddr = idx_nx[AW-1:0];
                        n_idx     = idx_nx[AW-1:0];
                    end else begin
                        n_used  = '0;
                        n_ovf   = 1'b0;
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= '0;
            r_used      <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_used      <= n_used;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sample   <= n_sample;
        r_out_data <= n_out_data;
        r_out_user <= n_out_user;
        r_out_last <= n_out_last;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;
    assign m_axis_tlast  = r_out_last;

endmodule

// ===== src/dvoc_ram.sv =====
// dvoc_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
module dvoc_ram #(
    parameter int WIDTH  = 64,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // read data holds while no read is issued
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/dvoc_checker.sv =====
// dvoc_checker: port-level assertions for the distinct value counter, bound to the top
// depends on dvoc_pkg
module dvoc_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic [dvoc_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    input logic                             s_axis_tuser,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [dvoc_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    input logic [dvoc_pkg::OUT_USER_W-1:0]  m_axis_tuser,
    input logic                             m_axis_tlast
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // s_axis_tready drops right after a flush request is taken
    a_flush_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == dvoc_pkg::OP_FLUSH)
        |=> !s_axis_tready)
        else $error("request taken right after a flush");

    // an empty-table result is the only and last one, with no data
    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[dvoc_pkg::UB_ENTRY_VALID]
        |-> m_axis_tlast && (m_axis_tdata == '0))
        else $error("empty flush result malformed");

    // no result right after reset
    a_reset_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !m_axis_tvalid)
        else $error("result offered after reset");

    // a valid entry never carries a zero count
    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[dvoc_pkg::UB_ENTRY_VALID]
        |-> (m_axis_tdata[dvoc_pkg::OUT_DATA_W-1:dvoc_pkg::VALUE_W] != '0))
        else $error("entry with zero count");

endmodule

bind distinct_value_occurrence_counter_unit dvoc_checker u_dvoc_checker (.*);

// ===== tb/sv/distinct_value_occurrence_counter_unit_tb.sv =====
// distinct_value_occurrence_counter_unit_tb: self-checking bench for the distinct value counter
// directed table then random insert/flush bursts, checked against a local copy of the table
// depends on dvoc_pkg and the distinct_value_occurrence_counter_unit rtl
`timescale 1ns / 1ps

module distinct_value_occurrence_counter_unit_tb;

    localparam int TABLE_DEPTH  = dvoc_pkg::CAPACITY_DEF;
    localparam int TOTAL_ITEMS  = 330;
    localparam int DIRECTED_LEN = 15;

    typedef struct packed {
        dvoc_pkg::t_value value;
        dvoc_pkg::t_count count;
        logic             valid;
        logic             ovf;
        logic             last;
    } t_entry;

    typedef struct packed {
        logic             op;
        dvoc_pkg::t_value value;
        logic             typed;   // expected result written in the row
        t_entry           exp;
    } t_stim_row;

    localparam t_entry NO_EXP = '0;

    // empty flushes and a single-entry flush carry their result in the row
    localparam t_stim_row DIRECTED_ROWS [DIRECTED_LEN] = '{
        '{dvoc_pkg::OP_FLUSH,  32'h0000_0000, 1'b1, '{32'h0, 32'h0, 1'b0, 1'b0, 1'b1}},
        '{dvoc_pkg::OP_INSERT, 32'h8000_0000, 1'b0, NO_EXP},
        '{dvoc_pkg::OP_INSERT, 32'h7FFF_FFFF, 1'b0, NO_EXP},
        '{dvoc_pkg::OP_INSERT, 32'h8000_0000, 1'b0, NO_EXP},
        '{dvoc_pkg::OP_INSERT, 32'h0000_0000, 1'b0, NO_EXP},
        '{dvoc_pkg::OP_INSERT, 32'hFFFF_FFFF, 1'b0, NO_EXP},
        '{dvoc_pkg::OP_INSERT, 32'h7FFF_FFFF, 1'b0, NO_EXP},
        '{dvoc_pkg::OP_FLUSH,  32'h1234_5678, 1'b0, NO_EXP},
        '{dvoc_pkg::OP_FLUSH,  32'hFFFF_FFFF, 1'b1, '{32'h0, 32'h0, 1'b0, 1'b0, 1'b1}},
        '{dvoc_pkg::OP_INSERT, 32'hAAAA_AAAA, 1'b0, NO_EXP},
        '{dvoc_pkg::OP_INSERT, 32'h5555_5555, 1'b0, NO_EXP},
        '{dvoc_pkg::OP_INSERT, 32'hAAAA_AAAA, 1'b0, NO_EXP},
        '{dvoc_pkg::OP_FLUSH,  32'hDEAD_BEEF, 1'b0, NO_EXP},
        '{dvoc_pkg::OP_INSERT, 32'h0000_0001, 1'b0, NO_EXP},
        '{dvoc_pkg::OP_FLUSH,  32'h0000_0000, 1'b1, '{32'h1, 32'h1, 1'b1, 1'b0, 1'b1}}
    };

    localparam dvoc_pkg::t_value EXTREME_VALUES [5] = '{
        32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001
    };

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             s_axis_tvalid;
    logic                             s_axis_tready;
    logic [dvoc_pkg::IN_DATA_W-1:0]   s_axis_tdata;   // [31:0] sample_value
    logic                             s_axis_tuser;   // [0] opcode
    logic                             m_axis_tvalid;
    logic                             m_axis_tready;
    logic [dvoc_pkg::OUT_DATA_W-1:0]  m_axis_tdata;   // [31:0] entry_value, [63:32] entry_count
    logic [dvoc_pkg::OUT_USER_W-1:0]  m_axis_tuser;   // [0] entry_valid, [1] overflow_seen
    logic                             m_axis_tlast;   // last_entry

    distinct_value_occurrence_counter_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // local copy of the value table
    dvoc_pkg::t_value tally_value [TABLE_DEPTH];
    dvoc_pkg::t_count tally_count [TABLE_DEPTH];
    int               tally_used;
    logic             tally_ovf;

    t_entry pending_entries [$];
    int     mismatches;
    int     items_sent;
    int     sender_gap;
    int     receiver_stall;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("FAIL distinct_value_occurrence_counter_unit");
        $finish;
    end

    // updates the table for one accepted request, queues the entries a flush emits
    function automatic int tally_step(input logic op, input dvoc_pkg::t_value value);
        int   slot;
        int   emitted;
        logic found;
        found = 1'b0;
        if (op == dvoc_pkg::OP_INSERT) begin
            for (slot = 0; slot < tally_used; slot++) begin
                if (!found && tally_value[slot] == value) begin
                    found = 1'b1;
                    if (tally_count[slot] != '1) begin
                        tally_count[slot]++;
                    end
                end
            end
            if (!found) begin
                if (tally_used < TABLE_DEPTH) begin
                    tally_value[tally_used] = value;
                    tally_count[tally_used] = dvoc_pkg::t_count'(1);
                    tally_used++;
                end else begin
                    tally_ovf = 1'b1;
                end
            end
            return 0;
        end
        if (tally_used == 0) begin
            pending_entries.push_back('{'0, '0, 1'b0, tally_ovf, 1'b1});
            emitted = 1;
        end else begin
            for (slot = 0; slot < tally_used; slot++) begin
                pending_entries.push_back('{tally_value[slot], tally_count[slot], 1'b1,
                                            tally_ovf, slot == tally_used - 1});
            end
            emitted = tally_used;
        end
        tally_used = 0;
        tally_ovf  = 1'b0;
        return emitted;
    endfunction

    task automatic send_request(input logic op, input dvoc_pkg::t_value value,
                                input logic typed, input t_entry exp);
        int n;
        @(negedge i_clk);
        while ($urandom_range(99) < sender_gap) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        n = tally_step(op, value);
        if (typed) begin
            repeat (n) void'(pending_entries.pop_back());
            pending_entries.push_back(exp);
        end
        items_sent++;
    endtask

    task automatic hold_until_drained();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_entries.size() != 0) @(posedge i_clk);
    endtask

    task automatic flag_mismatch(input string what, input t_entry want, input t_entry got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%0t %s: exp val=%h cnt=%h v=%b o=%b l=%b got val=%h cnt=%h v=%b o=%b l=%b",
                     $realtime, what, want.value, want.count, want.valid, want.ovf, want.last,
                     got.value, got.count, got.valid, got.ovf, got.last);
        end
    endtask

    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            m_axis_tready <= ($urandom_range(99) >= receiver_stall);
        end
    end

    always @(posedge i_clk) begin : check_results
        t_entry got;
        t_entry want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = '{m_axis_tdata[31:0], m_axis_tdata[63:32],
                    m_axis_tuser[dvoc_pkg::UB_ENTRY_VALID],
                    m_axis_tuser[dvoc_pkg::UB_OVERFLOW_SEEN], m_axis_tlast};
            if (pending_entries.size() == 0) begin
                flag_mismatch("unexpected entry", NO_EXP, got);
            end else begin
                want = pending_entries.pop_front();
                if (got.value !== want.value) flag_mismatch("entry_value", want, got);
                if (got.count !== want.count) flag_mismatch("entry_count", want, got);
                if (got.valid !== want.valid) flag_mismatch("entry_valid", want, got);
                if (got.ovf !== want.ovf) flag_mismatch("overflow_seen", want, got);
                if (got.last !== want.last) flag_mismatch("last_entry", want, got);
            end
        end
    end

    initial begin : stimulus
        dvoc_pkg::t_value pool [8];
        dvoc_pkg::t_value base;
        dvoc_pkg::t_value value;
        int               phase;
        int               phase_end;
        int               pool_size;
        int               burst;
        int               pick;
        int               i;

        i_rst_n        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = dvoc_pkg::OP_INSERT;
        mismatches     = 0;
        items_sent     = 0;
        tally_used     = 0;
        tally_ovf      = 1'b0;
        sender_gap     = 29;
        receiver_stall = 51;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (i = 0; i < DIRECTED_LEN; i++) begin
            send_request(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].value,
                         DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].exp);
        end

        for (phase = 0; phase < 3; phase++) begin
            sender_gap     = (phase == 0) ? 29 : (phase == 1) ? 51 : 0;
            receiver_stall = (phase == 0) ? 51 : (phase == 1) ? 29 : 0;
            phase_end = DIRECTED_LEN + (TOTAL_ITEMS - DIRECTED_LEN) * (phase + 1) / 3;

            // fill the table, then push past it with new and already stored values
            if (phase < 2) begin
                base = $urandom;
                i = 0;
                while (tally_used < TABLE_DEPTH) begin
                    if (i > 0 && $urandom_range(3) == 0) begin
                        send_request(dvoc_pkg::OP_INSERT, base + $urandom_range(i - 1),
                                     1'b0, NO_EXP);
                    end else begin
                        send_request(dvoc_pkg::OP_INSERT, base + i, 1'b0, NO_EXP);
                        i++;
                    end
                end
                burst = $urandom_range(6, 2);
                for (i = 0; i < burst; i++) begin
                    if ($urandom_range(1) == 0) begin
                        send_request(dvoc_pkg::OP_INSERT, base + 32'd1000 + i, 1'b0, NO_EXP);
                    end else begin
                        send_request(dvoc_pkg::OP_INSERT,
                                     base + $urandom_range(TABLE_DEPTH - 1), 1'b0, NO_EXP);
                    end
                end
                send_request(dvoc_pkg::OP_FLUSH, $urandom, 1'b0, NO_EXP);
            end

            while (items_sent < phase_end) begin
                pick = $urandom_range(99);
                if (pick < 75) begin
                    // burst of inserts over a small pool so values repeat, then a flush
                    pool_size = $urandom_range(8, 1);
                    for (i = 0; i < pool_size; i++) begin
                        pool[i] = ($urandom_range(4) == 0) ? EXTREME_VALUES[$urandom_range(4)]
                                                           : dvoc_pkg::t_value'($urandom);
                    end
                    burst = $urandom_range(12, 1);
                    for (i = 0; i < burst; i++) begin
                        send_request(dvoc_pkg::OP_INSERT, pool[$urandom_range(pool_size - 1)],
                                     1'b0, NO_EXP);
                    end
                    send_request(dvoc_pkg::OP_FLUSH, $urandom, 1'b0, NO_EXP);
                end else if (pick < 87) begin
                    send_request(dvoc_pkg::OP_FLUSH, $urandom, 1'b0, NO_EXP);
                end else begin
                    burst = $urandom_range(3, 1);
                    for (i = 0; i < burst; i++) begin
                        value = $urandom;
                        send_request(dvoc_pkg::OP_INSERT, value, 1'b0, NO_EXP);
                    end
                end
                if ($urandom_range(19) == 0) begin
                    hold_until_drained();
                end
            end
            hold_until_drained();
        end

        send_request(dvoc_pkg::OP_FLUSH, '0, 1'b0, NO_EXP);
        hold_until_drained();
        repeat (TABLE_DEPTH + 10) @(posedge i_clk);

        if (mismatches == 0 && pending_entries.size() == 0) begin
            $display("PASS distinct_value_occurrence_counter_unit");
        end else begin
            $display("FAIL distinct_value_occurrence_counter_unit");
        end
        $finish;
    end

endmodule

// ===== files.f =====
src/dvoc_pkg.sv
src/dvoc_ram.sv
src/distinct_value_occurrence_counter_unit.sv
src/dvoc_checker.sv
tb/sv/distinct_value_occurrence_counter_unit_tb.sv
